>>> src/q2e_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and functions of the quaternion to Euler angle unit.
package q2e_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int QUAT_FRAC_BITS    = 14;

   localparam int IN_W    = 16;
   localparam int ROLL_W  = 13;
   localparam int PITCH_W = 12;
   localparam int YAW_W   = 13;

   localparam int SUM_W = (2 * QUAT_FRAC_BITS + 2 > 34) ? 2 * QUAT_FRAC_BITS + 2 : 34;
   localparam int CW    = SUM_W + 3;
   localparam int ZW    = 32;
   localparam int IDX_W = 5;

   localparam int SQRT_STEPS = 31;
   localparam int SQ_W       = 62;

   localparam logic signed [ZW-1:0] ANG_PI_2 = 32'sd421657428;
   localparam logic [26:0] RAD_TO_UNITS = 27'd60078979;
   localparam int ROLL_LIM  = 2880;
   localparam int PITCH_LIM = 1440;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic roll_zero;
      logic pitch_zero;
      logic yaw_zero;
      logic sat_pos;
      logic sat_neg;
   } flag_type;

   // atan(2^-i), Q28 radians
   function automatic logic signed [ZW-1:0] atan_rom(input logic [IDX_W-1:0] i);
      logic signed [ZW-1:0] a;
      unique case (i)
         5'd0:  a = 32'sd210828714;
         5'd1:  a = 32'sd124459457;
         5'd2:  a = 32'sd65760959;
         5'd3:  a = 32'sd33381290;
         5'd4:  a = 32'sd16755422;
         5'd5:  a = 32'sd8385879;
         5'd6:  a = 32'sd4193963;
         5'd7:  a = 32'sd2097109;
         5'd8:  a = 32'sd1048571;
         5'd9:  a = 32'sd524287;
         5'd10: a = 32'sd262144;
         5'd11: a = 32'sd131072;
         5'd12: a = 32'sd65536;
         5'd13: a = 32'sd32768;
         5'd14: a = 32'sd16384;
         5'd15: a = 32'sd8192;
         5'd16: a = 32'sd4096;
         5'd17: a = 32'sd2048;
         5'd18: a = 32'sd1024;
         5'd19: a = 32'sd512;
         5'd20: a = 32'sd256;
         5'd21: a = 32'sd128;
         5'd22: a = 32'sd64;
         5'd23: a = 32'sd32;
         5'd24: a = 32'sd16;
         5'd25: a = 32'sd8;
         5'd26: a = 32'sd4;
         5'd27: a = 32'sd2;
         5'd28: a = 32'sd1;
         5'd29: a = 32'sd1;
         5'd30: a = 32'sd0;
         5'd31: a = 32'sd0;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

   // quarter turn into the right half plane
   function automatic cordic_type prerotate(input logic signed [CW-1:0] sy,
                                            input logic signed [CW-1:0] cx);
      cordic_type r;
      if (cx < 0) begin
         if (sy >= 0) begin
            r.x = sy;
            r.y = -cx;
            r.z = ANG_PI_2;
         end else begin
            r.x = -sy;
            r.y = cx;
            r.z = -ANG_PI_2;
         end
      end else begin
         r.x = cx;
         r.y = sy;
         r.z = '0;
      end
      return r;
   endfunction

endpackage

>>> src/q2e_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit step of the pipelined integer square root.
module q2e_sqrt_cell (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [q2e_pkg::IDX_W-1:0] step,
   input  logic [q2e_pkg::SQ_W-1:0] rem_cur,
   input  logic [q2e_pkg::SQ_W-1:0] res_cur,
   output logic [q2e_pkg::SQ_W-1:0] rem_nxt,
   output logic [q2e_pkg::SQ_W-1:0] res_nxt
);
   import q2e_pkg::*;

   localparam logic [5:0] TOP_POS = 6'(2 * (SQRT_STEPS - 1));

   logic [5:0]      bit_pos;
   logic [SQ_W-1:0] bit_val;
   logic [SQ_W-1:0] trial;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] res_ff, res_in;

   always_comb begin
      bit_pos = TOP_POS - {step, 1'b0};
      bit_val = SQ_W'(1) << bit_pos;
      trial   = res_cur + bit_val;
      if (rem_cur >= trial) begin
         rem_in = rem_cur - trial;
         res_in = (res_cur >> 1) + bit_val;
      end else begin
         rem_in = rem_cur;
         res_in = res_cur >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign rem_nxt = rem_ff;
   assign res_nxt = res_ff;
endmodule

>>> src/q2e_cordic_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation with its pipeline register.
module q2e_cordic_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [q2e_pkg::IDX_W-1:0] step,
   input  q2e_pkg::cordic_type       cur,
   output q2e_pkg::cordic_type       nxt
);
   import q2e_pkg::*;

   logic signed [CW-1:0] x, y, xs, ys;
   logic signed [ZW-1:0] z, a;
   cordic_type           st_ff, st_in;

   always_comb begin
      x  = cur.x;
      y  = cur.y;
      z  = cur.z;
      xs = x >>> step;
      ys = y >>> step;
      a  = atan_rom(step);
      if (y >= 0) begin
         st_in.x = x + ys;
         st_in.y = y - xs;
         st_in.z = z + a;
      end else begin
         st_in.x = x - ys;
         st_in.y = y + xs;
         st_in.z = z - a;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign nxt = st_ff;
endmodule

>>> src/quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// Quaternion to roll/pitch/yaw converter, fully pipelined.
// Takes one quaternion per cycle while the pipeline is not held and returns roll, pitch
// and yaw in 1/16 degree through its register stages: input, product and sum registers,
// a squaring stage, a stage that subtracts the square from one, 31 square-root digit
// cells for the pitch cosine, one quarter-turn stage, one CORDIC cell per iteration
// (three chains side by side) and a scaling multiply ahead of the output register. The
// whole pipeline holds while a response waits on rsp_ready.
module quaternion_to_euler_angles_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_x,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_y,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_z,
   input  logic signed [q2e_pkg::IN_W-1:0]     req_quat_w,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [q2e_pkg::ROLL_W-1:0]   rsp_roll_angle,
   output logic signed [q2e_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [q2e_pkg::YAW_W-1:0]    rsp_yaw_angle
);
   import q2e_pkg::*;

   localparam int ITER   = CORDIC_ITERATIONS;
   localparam int N_PIPE = 5 + SQRT_STEPS + 1 + ITER + 1;
   localparam int PROD_W = 2 * IN_W;
   localparam int SH_R   = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
   localparam int SH_L   = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;
   localparam int PW     = ZW + 27;
   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << (2 * QUAT_FRAC_BITS);
   localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

   typedef struct packed {
      cordic_type        roll;
      cordic_type        yaw;
      logic              roll_zero;
      logic              yaw_zero;
      logic              sat_pos;
      logic              sat_neg;
      logic signed [30:0] s30;
   } side_type;

   logic adv;
   logic [N_PIPE-1:0] vld_ff;
   logic rsp_valid_ff;

   // input stage
   logic signed [IN_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   // products
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff;
   // sums
   logic signed [SUM_W-1:0] sinr_ff, cosr_ff, sinp_ff, siny_ff, cosy_ff;
   logic signed [SUM_W-1:0] sinr_in, cosr_in, sinp_in, siny_in, cosy_in;
   // square stage
   side_type                 side3_ff, side3_in;
   logic signed [SQ_W-1:0]   sq3_ff;
   logic signed [SUM_W+SH_L-1:0] s30_wide;
   // sqrt line
   side_type        sd_ff [SQRT_STEPS+1];
   logic [SQ_W-1:0] rem_ch [SQRT_STEPS+1];
   logic [SQ_W-1:0] res_ch [SQRT_STEPS+1];
   logic [SQ_W-1:0] rem4_ff;
   // cordic chains
   cordic_type roll_ch [ITER+1];
   cordic_type pitch_ch [ITER+1];
   cordic_type yaw_ch [ITER+1];
   cordic_type rc_ff, pc_ff, yc_ff;
   flag_type   fl_ff [ITER+1];
   logic signed [CW-1:0] c30;
   // scaling
   logic signed [PW-1:0] rp_ff, pp_ff, yp_ff;
   flag_type             fs_ff;
   logic signed [ROLL_W-1:0]  roll_ff, roll_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [YAW_W-1:0]   yaw_ff, yaw_in;

   function automatic logic signed [15:0] to_units(input logic signed [PW-1:0] p,
                                                   input int lim);
      logic signed [PW:0] rnd;
      logic signed [PW:0] sh;
      logic signed [15:0] r;
      rnd = (PW+1)'(p) + ((PW+1)'(1) <<< 43);
      sh  = rnd >>> 44;
      if (sh > (PW+1)'(lim)) begin
         r = 16'(lim);
      end else if (sh < -((PW+1)'(lim))) begin
         r = -16'(lim);
      end else begin
         r = sh[15:0];
      end
      return r;
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[N_PIPE-2:0], req_valid};
         rsp_valid_ff <= vld_ff[N_PIPE-1];
      end
   end

   always_comb begin
      sinr_in = SUM_W'(2) * (SUM_W'(wx_ff) + SUM_W'(yz_ff));
      cosr_in = ONE - SUM_W'(2) * (SUM_W'(xx_ff) + SUM_W'(yy_ff));
      sinp_in = SUM_W'(2) * (SUM_W'(wy_ff) - SUM_W'(zx_ff));
      siny_in = SUM_W'(2) * (SUM_W'(wz_ff) + SUM_W'(xy_ff));
      cosy_in = ONE - SUM_W'(2) * (SUM_W'(yy_ff) + SUM_W'(zz_ff));

      s30_wide           = ((SUM_W+SH_L)'(sinp_ff) >>> SH_R) <<< SH_L;
      side3_in.s30       = s30_wide[30:0];
      side3_in.sat_pos   = sinp_ff >= ONE;
      side3_in.sat_neg   = sinp_ff <= -ONE;
      side3_in.roll      = prerotate(CW'(sinr_ff), CW'(cosr_ff));
      side3_in.yaw       = prerotate(CW'(siny_ff), CW'(cosy_ff));
      side3_in.roll_zero = (sinr_ff == '0) && (cosr_ff == '0);
      side3_in.yaw_zero  = (siny_ff == '0) && (cosy_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff    <= req_quat_x;
         qy_ff    <= req_quat_y;
         qz_ff    <= req_quat_z;
         qw_ff    <= req_quat_w;
         xx_ff    <= qx_ff * qx_ff;
         yy_ff    <= qy_ff * qy_ff;
         zz_ff    <= qz_ff * qz_ff;
         wx_ff    <= qw_ff * qx_ff;
         yz_ff    <= qy_ff * qz_ff;
         wy_ff    <= qw_ff * qy_ff;
         zx_ff    <= qz_ff * qx_ff;
         wz_ff    <= qw_ff * qz_ff;
         xy_ff    <= qx_ff * qy_ff;
         sinr_ff  <= sinr_in;
         cosr_ff  <= cosr_in;
         sinp_ff  <= sinp_in;
         siny_ff  <= siny_in;
         cosy_ff  <= cosy_in;
         side3_ff <= side3_in;
         sq3_ff   <= SQ_W'(side3_in.s30) * SQ_W'(side3_in.s30);
         rem4_ff  <= SQ_ONE - SQ_W'(sq3_ff);
         sd_ff[0] <= side3_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   assign rem_ch[0] = rem4_ff;
   assign res_ch[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock   (clock),
         .enable  (adv),
         .step    (IDX_W'(k)),
         .rem_cur (rem_ch[k]),
         .res_cur (res_ch[k]),
         .rem_nxt (rem_ch[k+1]),
         .res_nxt (res_ch[k+1])
      );
   end

   assign c30 = CW'($signed({1'b0, res_ch[SQRT_STEPS][30:0]}));

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ff                <= sd_ff[SQRT_STEPS].roll;
         yc_ff                <= sd_ff[SQRT_STEPS].yaw;
         pc_ff                <= prerotate(CW'(sd_ff[SQRT_STEPS].s30), c30);
         fl_ff[0].roll_zero   <= sd_ff[SQRT_STEPS].roll_zero;
         fl_ff[0].yaw_zero    <= sd_ff[SQRT_STEPS].yaw_zero;
         fl_ff[0].pitch_zero  <= (sd_ff[SQRT_STEPS].s30 == '0) && (c30 == '0);
         fl_ff[0].sat_pos     <= sd_ff[SQRT_STEPS].sat_pos;
         fl_ff[0].sat_neg     <= sd_ff[SQRT_STEPS].sat_neg;
         for (int k = 0; k < ITER; k++) begin
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   assign roll_ch[0]  = rc_ff;
   assign pitch_ch[0] = pc_ff;
   assign yaw_ch[0]   = yc_ff;

   for (genvar i = 0; i < ITER; i++) begin : g_cordic
      q2e_cordic_cell u_roll (
         .clock  (clock),
         .enable (adv),
         .step   (IDX_W'(i)),
         .cur    (roll_ch[i]),
         .nxt    (roll_ch[i+1])
      );
      q2e_cordic_cell u_pitch (
         .clock  (clock),
         .enable (adv),
         .step   (IDX_W'(i)),
         .cur    (pitch_ch[i]),
         .nxt    (pitch_ch[i+1])
      );
      q2e_cordic_cell u_yaw (
         .clock  (clock),
         .enable (adv),
         .step   (IDX_W'(i)),
         .cur    (yaw_ch[i]),
         .nxt    (yaw_ch[i+1])
      );
   end

   always_comb begin
      roll_in  = fs_ff.roll_zero ? '0 : ROLL_W'(to_units(rp_ff, ROLL_LIM));
      yaw_in   = fs_ff.yaw_zero ? '0 : YAW_W'(to_units(yp_ff, ROLL_LIM));
      priority if (fs_ff.sat_pos) begin
         pitch_in = PITCH_W'(PITCH_LIM);
      end else if (fs_ff.sat_neg) begin
         pitch_in = -PITCH_W'(PITCH_LIM);
      end else if (fs_ff.pitch_zero) begin
         pitch_in = '0;
      end else begin
         pitch_in = PITCH_W'(to_units(pp_ff, PITCH_LIM));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rp_ff    <= PW'(roll_ch[ITER].z) * PW'($signed({1'b0, RAD_TO_UNITS}));
         pp_ff    <= PW'(pitch_ch[ITER].z) * PW'($signed({1'b0, RAD_TO_UNITS}));
         yp_ff    <= PW'(yaw_ch[ITER].z) * PW'($signed({1'b0, RAD_TO_UNITS}));
         fs_ff    <= fl_ff[ITER];
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;
endmodule

>>> src/q2e_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the quaternion to Euler angle unit and their binding.
module q2e_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [q2e_pkg::IN_W-1:0]     req_quat_x,
   input logic signed [q2e_pkg::IN_W-1:0]     req_quat_y,
   input logic signed [q2e_pkg::IN_W-1:0]     req_quat_z,
   input logic signed [q2e_pkg::IN_W-1:0]     req_quat_w,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [q2e_pkg::ROLL_W-1:0]   rsp_roll_angle,
   input logic signed [q2e_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   input logic signed [q2e_pkg::YAW_W-1:0]    rsp_yaw_angle
);
   import q2e_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_angle)
         && $stable(rsp_roll_angle) && $stable(rsp_yaw_angle))
      else $error("stalled response changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !rsp_ready) |-> req_ready)
      else $error("request refused with response side free");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= PITCH_W'(PITCH_LIM)
         && rsp_pitch_angle >= -PITCH_W'(PITCH_LIM))
      else $error("pitch out of range");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_angle <= ROLL_W'(ROLL_LIM)
         && rsp_roll_angle >= -ROLL_W'(ROLL_LIM)
         && rsp_yaw_angle <= YAW_W'(ROLL_LIM) && rsp_yaw_angle >= -YAW_W'(ROLL_LIM))
      else $error("roll or yaw out of range");
endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (.*);

>>> dv/quaternion_to_euler_angles_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the quaternion to Euler angle converter.
module quaternion_to_euler_angles_unit_tb;
   import q2e_pkg::*;

   localparam int RANDOM_ITEMS = 430;
   localparam int DRAIN_CYCLES = 120;
   localparam longint SCALE_Q16 = 60078979;
   localparam longint QUARTER_TURN = 421657428;

   typedef struct {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
   } angles_type;

   typedef struct {
      logic signed [IN_W-1:0] x, y, z, w;
      bit pitch_known;
      logic signed [PITCH_W-1:0] pitch;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic signed [YAW_W-1:0]   rsp_yaw_angle;

   angles_type pending_angles[$];
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int saturated_seen = 0;
   bit quiet_phase = 1'b0;
   bit pitch_override = 1'b0;
   logic signed [PITCH_W-1:0] pitch_forced;

   quaternion_to_euler_angles_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint atan_entry(int i);
      longint acc;
      longint e;
      if (i == 0) return 210828714;
      acc = 0;
      for (int n = 0; n < 64; n++) begin
         e = i * (2 * n + 1);
         if (e > 62) break;
         if (n % 2) acc -= (64'sd1 <<< (62 - e)) / (2 * n + 1);
         else acc += (64'sd1 <<< (62 - e)) / (2 * n + 1);
      end
      return (acc + (64'sd1 <<< 33)) >>> 34;
   endfunction

   function automatic longint vector_angle(longint sy, longint cx);
      longint vx, vy, ang, sx, sy_s;
      vx = cx; vy = sy; ang = 0;
      if (vx == 0 && vy == 0) return 0;
      if (vx < 0) begin
         if (vy >= 0) begin
            vx = sy; vy = -cx; ang = QUARTER_TURN;
         end else begin
            vx = -sy; vy = cx; ang = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         sx = vx >>> i;
         sy_s = vy >>> i;
         if (vy >= 0) begin
            vx = vx + sy_s; vy = vy - sx; ang += atan_entry(i);
         end else begin
            vx = vx - sy_s; vy = vy + sx; ang -= atan_entry(i);
         end
      end
      return ang;
   endfunction

   function automatic longint scale_to_sixteenths(longint rad, longint lim);
      longint r;
      r = (rad * SCALE_Q16 + (64'sd1 <<< 43)) >>> 44;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic angles_type euler_angles_of(logic signed [IN_W-1:0] x, y, z, w);
      angles_type a;
      longint qx, qy, qz, qw, one, sinr, cosr, sinp, siny, cosy, s30, c30;
      qx = x; qy = y; qz = z; qw = w;
      one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
      sinr = 2 * (qw * qx + qy * qz);
      cosr = one - 2 * (qx * qx + qy * qy);
      sinp = 2 * (qw * qy - qz * qx);
      siny = 2 * (qw * qz + qx * qy);
      cosy = one - 2 * (qy * qy + qz * qz);
      a.roll = ROLL_W'(scale_to_sixteenths(vector_angle(sinr, cosr), ROLL_LIM));
      a.yaw = YAW_W'(scale_to_sixteenths(vector_angle(siny, cosy), ROLL_LIM));
      if (sinp >= one) a.pitch = PITCH_W'(PITCH_LIM);
      else if (sinp <= -one) a.pitch = -PITCH_W'(PITCH_LIM);
      else begin
         if (2 * QUAT_FRAC_BITS >= 30) s30 = sinp >>> (2 * QUAT_FRAC_BITS - 30);
         else s30 = sinp * (64'sd1 <<< (30 - 2 * QUAT_FRAC_BITS));
         c30 = int_sqrt((64'd1 << 60) - longint'(s30 * s30));
         a.pitch = PITCH_W'(scale_to_sixteenths(vector_angle(s30, c30), PITCH_LIM));
      end
      return a;
   endfunction

   // request side: predict on acceptance
   always @(posedge clock) begin
      angles_type e;
      if (!reset && req_valid && req_ready) begin
         e = euler_angles_of(req_quat_x, req_quat_y, req_quat_z, req_quat_w);
         if (pitch_override) e.pitch = pitch_forced;
         pending_angles.push_back(e);
      end
   end

   // response side: compare with oldest prediction
   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (rsp_pitch_angle == PITCH_LIM || rsp_pitch_angle == -PITCH_LIM) saturated_seen++;
         if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $time);
         end else begin
            e = pending_angles.pop_front();
            if (e.roll !== rsp_roll_angle || e.pitch !== rsp_pitch_angle ||
                e.yaw !== rsp_yaw_angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp r/p/y %0d %0d %0d, got %0d %0d %0d", $time,
                           e.roll, e.pitch, e.yaw,
                           rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle);
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off, none at the end
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && requests_sent >= 150) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_request(logic signed [IN_W-1:0] x, y, z, w);
      req_valid <= 1'b1;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      req_quat_w <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic signed [IN_W-1:0] to_q14(real v);
      return IN_W'($rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5)));
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      real a, b, c, d, n;
      rows = '{
         '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 1'b1, 12'sd1440},
         '{16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 1'b1, -12'sd1440},
         '{16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 1'b0, '0},
         '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0, '0},
         '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, '0},
         '{-16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b0, '0},
         '{16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 1'b0, '0},
         '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, '0},
         '{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 1'b0, '0},
         '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
         '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0},
         '{16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 1'b1, 12'sd1440},
         '{16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 1'b1, -12'sd1440},
         '{16'sd1, 16'sd0, 16'sd0, 16'sd16384, 1'b0, '0},
         '{16'sd0, -16'sd1, 16'sd0, 16'sd16384, 1'b0, '0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         r = rows[i];
         pitch_override <= r.pitch_known;
         pitch_forced <= r.pitch;
         send_request(r.x, r.y, r.z, r.w);
      end
      pitch_override <= 1'b0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 300) begin
            req_valid <= 1'b0;
            while (pending_angles.size() != 0) @(posedge clock);
         end
         if (k == RANDOM_ITEMS - 60) quiet_phase = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            send_request(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
         end else begin
            a = $urandom_range(0, 2000) - 1000.0;
            b = $urandom_range(0, 2000) - 1000.0;
            c = $urandom_range(0, 2000) - 1000.0;
            d = $urandom_range(0, 2000) - 1000.0;
            // push some toward gimbal lock
            if ($urandom_range(0, 5) == 0) begin
               c = a * (($urandom_range(0, 1)) ? 1.0 : -1.0);
               d = b;
            end
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n == 0.0) n = 1.0;
            send_request(to_q14(a / n), to_q14(b / n), to_q14(c / n), to_q14(d / n));
         end
      end
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests (directed extremes, unit and raw quaternions)", requests_sent);
      $display("checked %0d responses, %0d with pitch at gimbal lock", responses_seen,
               saturated_seen);
      if (mismatches == 0 && pending_angles.size() == 0)
         $display("quaternion_to_euler_angles_unit_tb: done, clean");
      else
         $display("quaternion_to_euler_angles_unit_tb: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("quaternion_to_euler_angles_unit_tb: done, errors");
      $finish;
   end

endmodule
